[rtl/ryk_pkg.sv]
// shared types, constants and helpers for the regularized yukawa potential sum core
// no dependencies; imported by every module of the block
package ryk_pkg;

    localparam int MAX_POINTS_DEF = 1024;
    localparam int POS_W          = 32;
    localparam int POT_W          = 64;
    localparam int DIVD_W         = 64;
    localparam int DIVS_W         = 40;
    localparam int ROOT_IN_W      = 64;
    localparam int R2_W           = 51;
    localparam int IN_DATA_W      = 192;
    localparam int IN_USER_W      = 2;

    localparam logic [31:0] KAPPA_RST = 32'd16777216;
    localparam logic [31:0] EPS_RST   = 32'd1677722;
    localparam logic [23:0] LN2_Q24   = 24'd11629080;
    localparam logic [24:0] LN2_RECIP = 25'((64'd1 << 48) / {40'd0, LN2_Q24});
    localparam logic [3:0]  EXP_TERMS = 4'd10;
    localparam logic [32:0] ONE_Q32   = 33'h1_0000_0000;
    localparam logic [63:0] POT_MAX   = 64'h7fff_ffff_ffff_ffff;
    localparam logic [63:0] POT_MIN   = 64'h8000_0000_0000_0000;

    typedef enum logic [0:0] {
        CFG_KAPPA = 1'b0,
        CFG_EPS   = 1'b1
    } cfg_idx_t;

    typedef enum logic [0:0] {
        OP_LOAD = 1'b0,
        OP_EVAL = 1'b1
    } item_op_t;

    typedef enum logic [4:0] {
        DP_NOP,
        DP_LOAD,
        DP_EVAL_INIT,
        DP_E2,
        DP_MEM_RD,
        DP_SQ_X,
        DP_SQ_Y,
        DP_SQ_Z,
        DP_SQRT_START,
        DP_KX,
        DP_ZERO_TERM,
        DP_DIV_LN2,
        DP_LN2_CAP,
        DP_POLY_MUL,
        DP_DIV_K,
        DP_POLY_UPD,
        DP_EXP,
        DP_PROD,
        DP_DIV_Q,
        DP_TERM,
        DP_ACC,
        DP_OUT
    } dp_op_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_E2,
        ST_CHECK,
        ST_SQX,
        ST_SQY,
        ST_SQZ,
        ST_SQRT_GO,
        ST_SQRT_WAIT,
        ST_KX,
        ST_LN2_GO,
        ST_LN2_WAIT,
        ST_PMUL,
        ST_KDIV_GO,
        ST_KDIV_WAIT,
        ST_EXP,
        ST_PROD,
        ST_QDIV_GO,
        ST_QDIV_WAIT,
        ST_ACC,
        ST_FINAL
    } state_t;

    typedef struct packed {
        logic idx_end;
        logic q_zero;
        logic sqrt_busy;
        logic div_busy;
        logic k_last;
        logic out_busy;
    } dp_status_t;

    typedef struct packed {
        logic [63:0] val;
        logic        ovf;
    } sat_t;

    function automatic sat_t sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        sat_t        r;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63])
        begin
            r.ovf = 1'b1;
            r.val = s[64] ? POT_MIN : POT_MAX;
        end
        else
        begin
            r.ovf = 1'b0;
            r.val = s[63:0];
        end
        return r;
    endfunction

    // floor(2^33 / k) for the series divisors
    function automatic logic [33:0] k_recip(input logic [3:0] k);
        logic [33:0] r;
        unique case (k)
            4'd1:    r = 34'((64'd1 << 33) / 64'd1);
            4'd2:    r = 34'((64'd1 << 33) / 64'd2);
            4'd3:    r = 34'((64'd1 << 33) / 64'd3);
            4'd4:    r = 34'((64'd1 << 33) / 64'd4);
            4'd5:    r = 34'((64'd1 << 33) / 64'd5);
            4'd6:    r = 34'((64'd1 << 33) / 64'd6);
            4'd7:    r = 34'((64'd1 << 33) / 64'd7);
            4'd8:    r = 34'((64'd1 << 33) / 64'd8);
            4'd9:    r = 34'((64'd1 << 33) / 64'd9);
            4'd10:   r = 34'((64'd1 << 33) / 64'd10);
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

[rtl/regularized_yukawa_potential_sum_core.sv]
// top level of the regularized yukawa potential sum core
// depends on ryk_pkg, ryk_ctrl, ryk_datapath
//
// input stream: a load beat (tuser op 0) stores one point (position, charge);
// tuser restart empties the store first; loads past MAX_POINTS are dropped.
// an evaluate beat (tuser op 1) carries a target position and a prior potential and
// yields one output beat: prior plus the sum over all stored points, saturating.
// evaluation walks the stored points one after another: two square root units, a
// reciprocal ln2 reduction and ten reciprocal series steps, then a restoring divide
// for the final quotient; a point whose denominator is zero skips the reduction,
// the series and the divide.
// the output beat sits in a register; the next input beat is taken while it waits,
// but a new result is held back until the receiver has taken the previous one.
// configuration writes take effect at the next edge and must come while idle.
// reset empties the store, restores kappa and epsilon and drops any pending result.
module regularized_yukawa_potential_sum_core #(
    parameter int MAX_POINTS = ryk_pkg::MAX_POINTS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [ryk_pkg::IN_DATA_W-1:0] s_tdata,  // pos_x, pos_y, pos_z, charge, prior_potential
    input  logic [ryk_pkg::IN_USER_W-1:0] s_tuser,  // op, restart
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [ryk_pkg::POT_W-1:0]     m_tdata,  // potential
    output logic                          m_tuser,  // saturated
    input  logic                          cfg_we,
    input  logic                          cfg_addr,
    input  logic [31:0]                   cfg_wdata
);
    import ryk_pkg::*;

    dp_op_t     op;
    dp_status_t status;

    ryk_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .item_op  (s_tuser[0]),
        .s_tready (s_tready),
        .status   (status),
        .op       (op)
    );

    ryk_datapath #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .op            (op),
        .status        (status),
        .item_data     (s_tdata),
        .item_restart  (s_tuser[1]),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_potential (m_tdata),
        .out_saturated (m_tuser)
    );

endmodule

[rtl/ryk_div.sv]
// iterative restoring divider, one quotient bit per cycle
// depends on ryk_pkg for widths
module ryk_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [ryk_pkg::DIVD_W-1:0] dividend,
    input  logic [ryk_pkg::DIVS_W-1:0] divisor,
    output logic                       busy,
    output logic [ryk_pkg::DIVD_W-1:0] quot
);
    import ryk_pkg::*;

    localparam int CNT_W = $clog2(DIVD_W);

    logic              busy_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [DIVD_W-1:0] quo_reg;
    logic [DIVS_W-1:0] rem_reg;
    logic [DIVS_W-1:0] dsr_reg;
    logic [DIVS_W:0]   rem_sh;
    logic [DIVS_W+1:0] diff;
    logic              ge;

    always_comb
    begin
        rem_sh = {rem_reg, quo_reg[DIVD_W-1]};
        diff   = {1'b0, rem_sh} - {2'b00, dsr_reg};
        ge     = ~diff[DIVS_W+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(DIVD_W - 1);
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
                busy_reg <= 1'b0;
            else
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DIVD_W-2:0], ge};
            rem_reg <= ge ? diff[DIVS_W-1:0] : rem_sh[DIVS_W-1:0];
        end
    end

    assign busy = busy_reg;
    assign quot = quo_reg;

endmodule

[rtl/ryk_isqrt.sv]
// iterative floor square root, consuming two bits of the radicand per cycle
// depends on ryk_pkg for widths
module ryk_isqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [ryk_pkg::ROOT_IN_W-1:0] radicand,
    output logic                          busy,
    output logic [ryk_pkg::ROOT_IN_W/2-1:0] root
);
    import ryk_pkg::*;

    localparam int STEPS = ROOT_IN_W / 2;
    localparam int CNT_W = $clog2(STEPS);

    logic                 busy_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [ROOT_IN_W-1:0] x_reg;
    logic [ROOT_IN_W-1:0] res_reg;
    logic [ROOT_IN_W-1:0] bit_reg;
    logic [ROOT_IN_W-1:0] trial;

    assign trial = res_reg + bit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(STEPS - 1);
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
                busy_reg <= 1'b0;
            else
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg   <= radicand;
            res_reg <= '0;
            bit_reg <= {2'b01, {(ROOT_IN_W-2){1'b0}}};
        end
        else if (busy_reg)
        begin
            if (x_reg >= trial)
            begin
                x_reg   <= x_reg - trial;
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
                res_reg <= res_reg >> 1;
            bit_reg <= bit_reg >> 2;
        end
    end

    assign busy = busy_reg;
    assign root = res_reg[ROOT_IN_W/2-1:0];

endmodule

[rtl/ryk_datapath.sv]
// datapath: point store, config registers, arithmetic units, accumulator, output register
// depends on ryk_pkg, ryk_div, ryk_isqrt
module ryk_datapath #(
    parameter int MAX_POINTS = ryk_pkg::MAX_POINTS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ryk_pkg::dp_op_t               op,
    output ryk_pkg::dp_status_t           status,
    input  logic [ryk_pkg::IN_DATA_W-1:0] item_data,
    input  logic                          item_restart,
    input  logic                          cfg_we,
    input  logic                          cfg_addr,
    input  logic [31:0]                   cfg_wdata,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [ryk_pkg::POT_W-1:0]     out_potential,
    output logic                          out_saturated
);
    import ryk_pkg::*;

    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

    logic [127:0] mem [MAX_POINTS];
    logic [127:0] rd_reg;

    logic [31:0]   kappa_reg;
    logic [31:0]   eps_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] idx_reg;
    logic [31:0]   tx_reg, ty_reg, tz_reg;
    logic [63:0]   prior_reg;
    logic [47:0]   e2_reg;
    logic [R2_W-1:0] r2_reg;
    logic [47:0]   x_reg;
    logic [6:0]    nq_reg;
    logic          n_big_reg;
    logic [5:0]    n_sh_reg;
    logic [23:0]   f_reg;
    logic [32:0]   t_reg;
    logic [3:0]    k_reg;
    logic [31:0]   p_reg;
    logic [31:0]   kq_reg;
    logic [32:0]   ex_reg;
    logic [63:0]   prod_reg;
    logic [63:0]   term_reg;
    logic [63:0]   sum_reg;
    logic          flag_reg;
    logic          out_valid_reg;
    logic [63:0]   out_pot_reg;
    logic          out_sat_reg;

    logic [CW-1:0] base;
    logic [31:0]   tsel, psel;
    logic [32:0]   diff, dmag;
    logic [63:0]   sq;
    logic [31:0]   chg;
    logic          chg_neg;
    logic [31:0]   chg_mag;
    logic [63:0]   e2_full, kx_full, pm_full;
    logic [64:0]   prod_full;
    logic [54:0]   nq_full;
    logic [30:0]   nl_full, fr_full, fr_adj;
    logic          fr_ge, x_big;
    logic [33:0]   krcp;
    logic [65:0]   kq_full;
    logic [35:0]   kqk, kr;
    logic          kge;
    logic [32:0]   kq_fix;
    logic          div_start;
    logic [DIVD_W-1:0] div_dvd;
    logic [DIVS_W-1:0] div_dsr;
    logic          div_busy;
    logic [DIVD_W-1:0] div_quot;
    logic          sqrt_start;
    logic          r_busy, q_busy;
    logic [ROOT_IN_W/2-1:0] r_root, q_root;
    sat_t          acc_sat, out_sat;

    assign base    = item_restart ? '0 : count_reg;
    assign chg     = rd_reg[127:96];
    assign chg_neg = chg[31];
    assign chg_mag = chg_neg ? (~chg + 32'd1) : chg;

    always_comb
    begin
        unique case (op)
            DP_SQ_Y:
            begin
                tsel = ty_reg;
                psel = rd_reg[63:32];
            end
            DP_SQ_Z:
            begin
                tsel = tz_reg;
                psel = rd_reg[95:64];
            end
            default:
            begin
                tsel = tx_reg;
                psel = rd_reg[31:0];
            end
        endcase
        diff = {tsel[31], tsel} - {psel[31], psel};
        dmag = diff[32] ? (~diff + 33'd1) : diff;
        sq   = dmag[31:0] * dmag[31:0];
    end

    assign e2_full   = eps_reg * eps_reg;
    assign kx_full   = kappa_reg * r_root;
    assign pm_full   = {40'd0, f_reg} * {31'd0, t_reg};
    assign prod_full = {33'd0, chg_mag} * {32'd0, ex_reg};
    assign acc_sat   = sat_add(sum_reg, term_reg);
    assign out_sat   = sat_add(prior_reg, sum_reg);

    // ln2 reduction by reciprocal, estimate is n or n - 1 below the cutoff
    assign x_big   = (x_reg >= {18'd0, LN2_Q24, 6'd0});
    assign nq_full = {25'd0, x_reg[29:0]} * {30'd0, LN2_RECIP};
    assign nl_full = {24'd0, nq_reg} * {7'd0, LN2_Q24};
    assign fr_full = {1'b0, x_reg[29:0]} - nl_full;
    assign fr_ge   = (fr_full >= {7'd0, LN2_Q24});
    assign fr_adj  = fr_full - {7'd0, LN2_Q24};

    // series divide by k through a reciprocal, one correction step
    assign krcp    = k_recip(k_reg);
    assign kq_full = {34'd0, p_reg} * {32'd0, krcp};
    assign kqk     = {4'd0, kq_reg} * {32'd0, k_reg};
    assign kr      = {4'd0, p_reg} - kqk;
    assign kge     = (kr >= {32'd0, k_reg});
    assign kq_fix  = {1'b0, kq_reg} + {32'd0, kge};

    assign div_start  = (op == DP_DIV_Q);
    assign div_dvd    = prod_reg;
    assign div_dsr    = {q_root, 8'd0};
    assign sqrt_start = (op == DP_SQRT_START);

    ryk_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dsr),
        .busy     (div_busy),
        .quot     (div_quot)
    );

    ryk_isqrt u_sqrt_r (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand ({{(ROOT_IN_W-R2_W){1'b0}}, r2_reg}),
        .busy     (r_busy),
        .root     (r_root)
    );

    ryk_isqrt u_sqrt_q (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand ({{(ROOT_IN_W-R2_W){1'b0}}, r2_reg + {3'd0, e2_reg}}),
        .busy     (q_busy),
        .root     (q_root)
    );

    // point store
    always_ff @(posedge clk)
    begin
        if (op == DP_LOAD && base < CW'(MAX_POINTS))
            mem[base[AW-1:0]] <= item_data[127:0];
        if (op == DP_MEM_RD)
            rd_reg <= mem[idx_reg[AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kappa_reg     <= KAPPA_RST;
            eps_reg       <= EPS_RST;
            count_reg     <= '0;
            idx_reg       <= '0;
            flag_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_idx_t'(cfg_addr))
                    CFG_KAPPA: kappa_reg <= cfg_wdata;
                    CFG_EPS:   eps_reg   <= cfg_wdata;
                    default:   kappa_reg <= kappa_reg;
                endcase
            end
            if (op == DP_LOAD)
            begin
                if (base < CW'(MAX_POINTS))
                    count_reg <= base + 1'b1;
                else
                    count_reg <= base;
            end
            if (op == DP_EVAL_INIT)
            begin
                idx_reg  <= '0;
                flag_reg <= 1'b0;
            end
            if (op == DP_ZERO_TERM)
                flag_reg <= 1'b1;
            if (op == DP_ACC)
            begin
                idx_reg <= idx_reg + 1'b1;
                if (acc_sat.ovf)
                    flag_reg <= 1'b1;
            end
            if (op == DP_OUT)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (op)
            DP_EVAL_INIT:
            begin
                tx_reg    <= item_data[31:0];
                ty_reg    <= item_data[63:32];
                tz_reg    <= item_data[95:64];
                prior_reg <= item_data[191:128];
                sum_reg   <= '0;
            end
            DP_E2:      e2_reg <= e2_full[63:16];
            DP_SQ_X:    r2_reg <= {3'd0, sq[63:16]};
            DP_SQ_Y,
            DP_SQ_Z:    r2_reg <= r2_reg + {3'd0, sq[63:16]};
            DP_KX:      x_reg  <= kx_full[63:16];
            DP_ZERO_TERM:
            begin
                if (chg_neg)
                    term_reg <= POT_MIN;
                else if (chg != '0)
                    term_reg <= POT_MAX;
                else
                    term_reg <= '0;
            end
            DP_DIV_LN2: nq_reg <= nq_full[54:48];
            DP_LN2_CAP:
            begin
                n_big_reg <= x_big;
                n_sh_reg  <= nq_reg[5:0] + {5'd0, fr_ge};
                f_reg     <= x_big ? '0 : (fr_ge ? fr_adj[23:0] : fr_full[23:0]);
                t_reg     <= ONE_Q32;
                k_reg     <= EXP_TERMS;
            end
            DP_POLY_MUL: p_reg <= pm_full[55:24];
            DP_DIV_K:    kq_reg <= kq_full[64:33];
            DP_POLY_UPD:
            begin
                t_reg <= ONE_Q32 - kq_fix;
                k_reg <= k_reg - 1'b1;
            end
            DP_EXP:     ex_reg   <= n_big_reg ? '0 : (t_reg >> n_sh_reg);
            DP_PROD:    prod_reg <= prod_full[63:0];
            DP_TERM:    term_reg <= chg_neg ? (~div_quot + 64'd1) : div_quot;
            DP_ACC:     sum_reg  <= acc_sat.val;
            DP_OUT:
            begin
                out_pot_reg <= out_sat.val;
                out_sat_reg <= flag_reg | out_sat.ovf;
            end
            default:    sum_reg  <= sum_reg;
        endcase
    end

    always_comb
    begin
        status.idx_end   = (idx_reg == count_reg);
        status.q_zero    = (q_root == '0);
        status.sqrt_busy = r_busy | q_busy;
        status.div_busy  = div_busy;
        status.k_last    = (k_reg == 4'd1);
        status.out_busy  = out_valid_reg & ~out_ready;
    end

    assign out_valid     = out_valid_reg;
    assign out_potential = out_pot_reg;
    assign out_saturated = out_sat_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_POINTS))
        else $error("point count beyond store depth");
    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider restarted while busy");
    a_k_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (op == DP_POLY_MUL || op == DP_DIV_K) |-> k_reg != 4'd0)
        else $error("series index reached zero");
    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        op == DP_MEM_RD |-> idx_reg < count_reg)
        else $error("read past stored points");
`endif

endmodule

[rtl/ryk_ctrl.sv]
// controller state machine sequencing the per-point evaluation
// depends on ryk_pkg for state, command and status types
module ryk_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    input  logic                item_op,
    output logic                s_tready,
    input  ryk_pkg::dp_status_t status,
    output ryk_pkg::dp_op_t     op
);
    import ryk_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        op         = DP_NOP;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    if (item_op_t'(item_op) == OP_EVAL)
                    begin
                        op         = DP_EVAL_INIT;
                        state_next = ST_E2;
                    end
                    else
                        op = DP_LOAD;
                end
            end
            ST_E2:
            begin
                op         = DP_E2;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (status.idx_end)
                    state_next = ST_FINAL;
                else
                begin
                    op         = DP_MEM_RD;
                    state_next = ST_SQX;
                end
            end
            ST_SQX:
            begin
                op         = DP_SQ_X;
                state_next = ST_SQY;
            end
            ST_SQY:
            begin
                op         = DP_SQ_Y;
                state_next = ST_SQZ;
            end
            ST_SQZ:
            begin
                op         = DP_SQ_Z;
                state_next = ST_SQRT_GO;
            end
            ST_SQRT_GO:
            begin
                op         = DP_SQRT_START;
                state_next = ST_SQRT_WAIT;
            end
            ST_SQRT_WAIT:
            begin
                if (!status.sqrt_busy)
                    state_next = ST_KX;
            end
            ST_KX:
            begin
                if (status.q_zero)
                begin
                    op         = DP_ZERO_TERM;
                    state_next = ST_ACC;
                end
                else
                begin
                    op         = DP_KX;
                    state_next = ST_LN2_GO;
                end
            end
            ST_LN2_GO:
            begin
                op         = DP_DIV_LN2;
                state_next = ST_LN2_WAIT;
            end
            ST_LN2_WAIT:
            begin
                op         = DP_LN2_CAP;
                state_next = ST_PMUL;
            end
            ST_PMUL:
            begin
                op         = DP_POLY_MUL;
                state_next = ST_KDIV_GO;
            end
            ST_KDIV_GO:
            begin
                op         = DP_DIV_K;
                state_next = ST_KDIV_WAIT;
            end
            ST_KDIV_WAIT:
            begin
                op         = DP_POLY_UPD;
                state_next = status.k_last ? ST_EXP : ST_PMUL;
            end
            ST_EXP:
            begin
                op         = DP_EXP;
                state_next = ST_PROD;
            end
            ST_PROD:
            begin
                op         = DP_PROD;
                state_next = ST_QDIV_GO;
            end
            ST_QDIV_GO:
            begin
                op         = DP_DIV_Q;
                state_next = ST_QDIV_WAIT;
            end
            ST_QDIV_WAIT:
            begin
                if (!status.div_busy)
                begin
                    op         = DP_TERM;
                    state_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                op         = DP_ACC;
                state_next = ST_CHECK;
            end
            ST_FINAL:
            begin
                if (!status.out_busy)
                begin
                    op         = DP_OUT;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[tb/tb.sv]
// testbench for regularized_yukawa_potential_sum_core: loads cluster points, evaluates targets
// and checks every potential beat against a bit-accurate predictor kept in a scoreboard class
// depends on ryk_pkg and the core rtl
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ryk_pkg::*;

    localparam int  NPTS      = 1024;
    localparam int  ITEM_GOAL = 540;
    localparam longint CYCLE_LIMIT = 20000000;

    typedef struct {
        logic [63:0] pot;
        logic        sat;
    } pot_result_t;

    class yukawa_sum_board;
        logic [31:0] kappa;
        logic [31:0] eps;
        logic [31:0] px[NPTS];
        logic [31:0] py[NPTS];
        logic [31:0] pz[NPTS];
        logic [31:0] pq[NPTS];
        int          count;
        pot_result_t awaited[$];
        int          errors;
        int          results_seen;
        int          sat_seen;

        function new();
            kappa = KAPPA_RST;
            eps   = EPS_RST;
            count = 0;
            errors = 0;
            results_seen = 0;
            sat_seen = 0;
        endfunction

        function automatic logic [63:0] floor_sqrt(logic [63:0] x);
            logic [63:0] res;
            logic [63:0] bt;
            res = 0;
            bt = 64'd1 << 62;
            for (int i = 0; i < 32; i++)
            begin
                if (x >= res + bt)
                begin
                    x = x - (res + bt);
                    res = (res >> 1) + bt;
                end
                else
                    res = res >> 1;
                bt = bt >> 2;
            end
            return res;
        endfunction

        function automatic logic [63:0] decay(logic [63:0] x);
            logic [63:0] n;
            logic [63:0] f;
            logic [63:0] t;
            n = x / LN2_Q24;
            f = x - n * LN2_Q24;
            t = 64'd1 << 32;
            for (int k = 10; k >= 1; k--)
                t = (64'd1 << 32) - (((f * t) >> 24) / k);
            if (n >= 64)
                return 64'd0;
            return t >> n;
        endfunction

        function automatic logic [63:0] dist_sq(logic [31:0] a, logic [31:0] b);
            logic signed [32:0] d;
            logic [63:0] m;
            d = $signed({a[31], a}) - $signed({b[31], b});
            m = d[32] ? 64'(-d) : 64'(d);
            return (m * m) >> 16;
        endfunction

        function automatic logic [63:0] clip_add(logic [63:0] a, logic [63:0] b, ref logic flag);
            logic [64:0] s;
            s = {a[63], a} + {b[63], b};
            if (s[64] != s[63])
            begin
                flag = 1'b1;
                return s[64] ? POT_MIN : POT_MAX;
            end
            return s[63:0];
        endfunction

        function void set_reg(cfg_idx_t idx, logic [31:0] v);
            if (idx == CFG_KAPPA)
                kappa = v;
            else
                eps = v;
        endfunction

        function void note_input(logic [1:0] user, logic [191:0] data);
            logic [63:0] e2, r2, r, q, ex, mag, quot, term, sum;
            logic signed [31:0] c;
            logic flag;
            pot_result_t res;
            if (item_op_t'(user[0]) == OP_LOAD)
            begin
                if (user[1])
                    count = 0;
                if (count < NPTS)
                begin
                    px[count] = data[31:0];
                    py[count] = data[63:32];
                    pz[count] = data[95:64];
                    pq[count] = data[127:96];
                    count++;
                end
                return;
            end
            flag = 1'b0;
            sum = 0;
            e2 = (64'(eps) * 64'(eps)) >> 16;
            for (int i = 0; i < count; i++)
            begin
                c = pq[i];
                r2 = dist_sq(data[31:0], px[i]) + dist_sq(data[63:32], py[i])
                   + dist_sq(data[95:64], pz[i]);
                r = floor_sqrt(r2);
                q = floor_sqrt(r2 + e2);
                if (q == 0)
                begin
                    flag = 1'b1;
                    term = (c > 0) ? POT_MAX : ((c < 0) ? POT_MIN : 64'd0);
                end
                else
                begin
                    ex = decay((64'(kappa) * r) >> 16);
                    mag = c[31] ? 64'(-64'(c)) : 64'(c);
                    quot = (mag * ex) / (q << 8);
                    term = c[31] ? -quot : quot;
                end
                sum = clip_add(sum, term, flag);
            end
            res.pot = clip_add(data[191:128], sum, flag);
            res.sat = flag;
            awaited.push_back(res);
        endfunction

        function void check_result(logic [63:0] pot, logic sat);
            pot_result_t e;
            results_seen++;
            if (sat)
                sat_seen++;
            if (awaited.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("tb: unexpected beat pot=%h sat=%b", pot, sat);
                return;
            end
            e = awaited.pop_front();
            if (pot !== e.pot || sat !== e.sat)
            begin
                errors++;
                if (errors <= 10)
                    $display("tb: mismatch exp pot=%h sat=%b got pot=%h sat=%b",
                             e.pot, e.sat, pot, sat);
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [IN_DATA_W-1:0] s_tdata;
    logic [IN_USER_W-1:0] s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [POT_W-1:0]     m_tdata;
    logic                 m_tuser;
    logic                 cfg_we;
    logic                 cfg_addr;
    logic [31:0]          cfg_wdata;

    yukawa_sum_board board;
    longint cycles;
    int     items_sent;
    int     evals_sent;
    bit     send_quiet;
    bit     recv_quiet;
    logic [31:0] last_x, last_y, last_z;

    regularized_yukawa_potential_sum_core dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: done, errors");
            $finish;
        end
    end

    // receiver with random stalls
    initial
    begin
        int stall;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = recv_quiet ? 0 : $urandom_range(0, 18);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            board.check_result(m_tdata, m_tuser);
        end
    end

    task automatic send_beat(item_op_t op, logic rs, logic [31:0] x, logic [31:0] y,
                             logic [31:0] z, logic [31:0] c, logic [63:0] prior);
        int gap;
        gap = send_quiet ? 0 : $urandom_range(0, 18);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= {rs, logic'(op)};
        s_tdata  <= {prior, c, z, y, x};
        do @(posedge clk); while (!s_tready);
        board.note_input({rs, logic'(op)}, {prior, c, z, y, x});
        items_sent++;
        if (op == OP_EVAL)
            evals_sent++;
        else
        begin
            last_x = x;
            last_y = y;
            last_z = z;
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.awaited.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_regs(logic [31:0] k, logic [31:0] e);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= CFG_KAPPA;
        cfg_wdata <= k;
        board.set_reg(CFG_KAPPA, k);
        @(posedge clk);
        cfg_addr <= CFG_EPS;
        cfg_wdata <= e;
        board.set_reg(CFG_EPS, e);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return $urandom();
            default: return 32'($signed($urandom_range(0, 1 << 26)) - (1 << 25));
        endcase
    endfunction

    function automatic logic [63:0] rand_prior();
        case ($urandom_range(0, 5))
            0: return POT_MAX - $urandom_range(0, 1 << 20);
            1: return POT_MIN + $urandom_range(0, 1 << 20);
            2: return {$urandom(), $urandom()};
            default: return 64'($signed($urandom()));
        endcase
    endfunction

    task automatic random_burst(int budget);
        int n;
        while (budget > 0)
        begin
            send_quiet = ($urandom_range(0, 7) == 0);
            recv_quiet = ($urandom_range(0, 7) == 0);
            if ($urandom_range(0, 9) == 0)
            begin
                // noise: lone beat of either kind
                send_beat(item_op_t'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          rand_coord(), rand_coord(), rand_coord(), $urandom(), rand_prior());
                budget--;
                continue;
            end
            n = $urandom_range(0, 3);
            send_beat(OP_LOAD, 1'b1, rand_coord(), rand_coord(), rand_coord(),
                      $urandom(), rand_prior());
            for (int i = 0; i < n; i++)
                send_beat(OP_LOAD, 1'b0, rand_coord(), rand_coord(), rand_coord(),
                          $urandom(), rand_prior());
            budget -= n + 1;
            n = $urandom_range(1, 2);
            for (int i = 0; i < n; i++)
            begin
                if ($urandom_range(0, 4) == 0)
                    send_beat(OP_EVAL, 1'($urandom_range(0, 1)), last_x, last_y, last_z,
                              $urandom(), rand_prior());
                else
                    send_beat(OP_EVAL, 1'($urandom_range(0, 1)), rand_coord(), rand_coord(),
                              rand_coord(), $urandom(), rand_prior());
            end
            budget -= n;
        end
    endtask

    initial
    begin
        board = new();
        cycles = 0;
        items_sent = 0;
        evals_sent = 0;
        send_quiet = 1'b0;
        recv_quiet = 1'b0;
        last_x = 0;
        last_y = 0;
        last_z = 0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        cfg_we = 1'b0;
        cfg_addr = CFG_KAPPA;
        cfg_wdata = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty store, extremes, zero denominator, overflow
        send_beat(OP_EVAL, 1'b0, 32'h7fff_ffff, 32'h8000_0000, 0, 0, POT_MAX);
        send_beat(OP_EVAL, 1'b1, 0, 0, 0, 32'hffff_ffff, POT_MIN);
        send_beat(OP_LOAD, 1'b1, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                  32'h7fff_ffff, 0);
        send_beat(OP_LOAD, 1'b0, 32'h0100_0000, 0, 0, 32'h8000_0000, 0);
        send_beat(OP_EVAL, 1'b0, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 0, 0);
        send_beat(OP_EVAL, 1'b0, 32'h0100_0000, 0, 0, 0, POT_MIN + 5);
        send_beat(OP_LOAD, 1'b1, 0, 0, 0, 32'h7fff_ffff, 0);
        send_beat(OP_EVAL, 1'b0, 32'h0000_1000, 0, 0, 0, POT_MAX - 3);
        drain();
        write_regs(32'd0, 32'd0);
        send_beat(OP_LOAD, 1'b0, 0, 0, 0, 32'h8000_0000, 0);
        send_beat(OP_LOAD, 1'b0, 0, 0, 0, 32'd0, 0);
        send_beat(OP_EVAL, 1'b0, 0, 0, 0, 0, 0);
        send_beat(OP_LOAD, 1'b1, 5, 5, 5, 32'd0, 0);
        send_beat(OP_EVAL, 1'b0, 5, 5, 5, 0, 64'd77);
        send_beat(OP_LOAD, 1'b1, 5, 5, 5, 32'h0000_0001, 0);
        send_beat(OP_EVAL, 1'b0, 5, 5, 5, 0, 64'd77);
        drain();
        write_regs(32'hffff_ffff, 32'hffff_ffff);
        send_beat(OP_LOAD, 1'b1, 0, 0, 0, 32'h7fff_ffff, 0);
        send_beat(OP_EVAL, 1'b0, 32'h0001_0000, 0, 0, 0, 0);
        drain();
        write_regs(KAPPA_RST, EPS_RST);

        random_burst(130);
        drain();
        write_regs($urandom(), $urandom_range(0, 1 << 24));
        random_burst(130);
        drain();
        write_regs(32'd0, 32'd0);
        random_burst(130);
        drain();
        write_regs(32'hffff_ffff, 32'hffff_ffff);
        random_burst(ITEM_GOAL - items_sent);

        drain();
        repeat (50) @(posedge clk);
        $display("tb: %0d input beats (%0d evaluates), %0d results checked, %0d saturated",
                 items_sent, evals_sent, board.results_seen, board.sat_seen);
        $display("tb: four register settings including zero and full scale, random stalls");
        if (board.errors == 0 && board.awaited.size() == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end
endmodule
